// File: hw/rtl/rqct_pkg.sv
// Package for the register query cache table: table depth, action codes, entry,
// request and result types and sequencer state type. No dependencies.
`default_nettype none
package rqct_pkg;
	// Table depth; the index fields of the request and result words assume 16
	localparam int NUM_ENTRIES = 16;

	typedef enum logic [3:0] {
		ACT_LOOKUP = 4'd0, ACT_ALLOC = 4'd1, ACT_MARK = 4'd2, ACT_AGE = 4'd3,
		ACT_FREE_ROLE = 4'd4, ACT_NEXT = 4'd5, ACT_FREE_ALL = 4'd6,
		ACT_FREE_ENTRY = 4'd7, ACT_UPDATE = 4'd8
	} action_t;

	typedef struct packed {
		logic [7:0]  role;
		logic [31:0] command;
		logic [31:0] argument;
		logic [7:0]  size;
		logic [31:0] time_v;
	} entry_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [7:0]  role;
		logic [31:0] command;
		logic [31:0] arg_value;
		logic [7:0]  response_size;
		logic [31:0] time_value;
		logic [4:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  result_index;
		logic [7:0]  result_size;
		logic [31:0] result_time;
	} rsp_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_FILL  = 7'b0000100,
		ST_SWAPA = 7'b0001000,
		ST_SWAPB = 7'b0010000,
		ST_RPT   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

// File: hw/rtl/rqct_if.sv
// Valid/ready channel carrying one payload word.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface rqct_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rqct_match.sv
// Shared entry compare unit: all per-entry tests for the scanning sequencer.
// Depends on rqct_pkg.
`default_nettype none
module rqct_match import rqct_pkg::*; (
	input  wire entry_t e,
	input  wire req_t   r,
	output logic        hit_lookup,
	output logic        hit_free,
	output logic        hit_role,
	output logic        hit_next,
	output logic        age_gt
);
	always_comb begin
		hit_role   = e.role == r.role;
		hit_lookup = hit_role && e.command == r.command && e.argument == r.arg_value;
		hit_free   = e.command == 32'd0;
		hit_next   = hit_role && e.command == r.command;
		age_gt     = e.time_v > r.time_value;
	end
endmodule
`default_nettype wire

// File: hw/rtl/register_query_cache_table.sv
// Register query cache table: fully associative, round-robin replacement.
// Scanning actions compare one entry per cycle in a single shared compare unit;
// single-entry actions check the index and go straight on to fill or report.
// One word at a time: in.ready only while idle, so each word is finished and its
// result taken by the output, after any output stall, before the next is taken.
// Reset: arst_n clears control and the latest pointer; entries are cleared
// through per-entry valid bits (an invalid entry reads as all zero).
`default_nettype none
module register_query_cache_table import rqct_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	rqct_if.sink   in,
	rqct_if.source out
);
	localparam int IW = $clog2(NUM_ENTRIES);

	// Entry store: one write per cycle, read combinationally
	// through the valid mask.
	entry_t              mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] vld_q;
	state_t              st_q;
	req_t                req_q;
	logic [IW:0]         ptr_q;   // scan index; the entry at NUM_ENTRIES - 1 is the last one scanned
	logic [IW-1:0]       latest_q, tgt_q, dst_q;
	logic                have_q;
	entry_t              tmp_q;   // held copy of the entry being swapped
	rsp_t                rsp_q;
	logic                ovld_q;

	logic [IW-1:0] rd_idx;
	entry_t        rd_e;
	logic          we;
	logic [IW-1:0] wa;
	entry_t        wd;
	logic hl, hf, hr, hn, ag;

	assign rd_e = vld_q[rd_idx] ? mem[rd_idx] : '0;

	rqct_match u_match (.e(rd_e), .r(req_q), .hit_lookup(hl), .hit_free(hf),
		.hit_role(hr), .hit_next(hn), .age_gt(ag));

	function automatic logic [IW-1:0] after(input logic [IW-1:0] i);
		return (32'(i) + 1 >= NUM_ENTRIES) ? '0 : IW'(32'(i) + 1);
	endfunction

	logic          idx_ok, last;
	logic [IW-1:0] pi;
	assign idx_ok = 32'(req_q.entry_index) < NUM_ENTRIES;
	assign pi     = ptr_q[IW-1:0];
	assign last   = 32'(ptr_q) + 1 >= NUM_ENTRIES;

	// Read address: scan pointer, swap source, or report target.
	always_comb begin
		unique case (st_q)
			ST_SWAPA, ST_SWAPB: rd_idx = (st_q == ST_SWAPA) ? dst_q : tgt_q;
			ST_RPT:             rd_idx = tgt_q;
			default:            rd_idx = pi;
		endcase
	end

	// Write port.
	always_comb begin
		we = 1'b0; wa = pi; wd = rd_e;
		unique case (st_q)
			ST_SCAN: begin
				priority case (action_t'(req_q.action))
					ACT_AGE: if (hr && ag) begin
						we = 1'b1; wd.time_v = req_q.time_value;
					end
					ACT_FREE_ROLE: if (hr) begin
						we = 1'b1; wd.command = '0; wd.size = '0;
					end
					ACT_FREE_ALL: begin
						we = 1'b1; wd.command = '0; wd.size = '0;
					end
					default: ;
				endcase
			end
			ST_FILL: begin
				// write the new entry for alloc only; mark_used just moves it
				wa = tgt_q; we = req_q.action == ACT_ALLOC;
				wd.role = req_q.role; wd.command = req_q.command;
				wd.argument = '0; wd.size = req_q.response_size;
				wd.time_v = mem[tgt_q].time_v & {32{vld_q[tgt_q]}};
			end
			ST_SWAPA: begin
				// hold dst contents in tmp, write target contents into dst
				we = 1'b1; wa = dst_q; wd = tmp_q;
			end
			ST_SWAPB: begin
				we = 1'b1; wa = tgt_q; wd = tmp_q;
			end
			ST_RPT: begin
				// free or update the single target entry while reporting it
				wa = tgt_q;
				if (have_q && req_q.action == ACT_FREE_ENTRY) begin
					we = 1'b1; wd.command = '0; wd.size = '0;
				end else if (have_q && req_q.action == ACT_UPDATE) begin
					we = 1'b1; wd.argument = req_q.arg_value;
					wd.time_v = req_q.time_value;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) if (we) mem[wa] <= wd;

	assign in.ready  = st_q == ST_IDLE;
	assign out.valid = ovld_q;
	assign out.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; vld_q <= '0; latest_q <= '0; ovld_q <= 1'b0;
			ptr_q <= '0; tgt_q <= '0; dst_q <= '0; have_q <= 1'b0;
			req_q <= '0; tmp_q <= '0; rsp_q <= '0;
		end else begin
			if (we) vld_q[wa] <= 1'b1;
			unique case (st_q)
				ST_IDLE: if (in.valid) begin
					req_q <= in.data; ptr_q <= '0; have_q <= 1'b0;
					rsp_q <= '0;
					tgt_q <= in.data.entry_index[IW-1:0];
					if (in.data.action == ACT_NEXT)
						ptr_q <= (32'(in.data.entry_index) < NUM_ENTRIES)
							? (IW+1)'(in.data.entry_index) : '0;
					st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					priority case (action_t'(req_q.action))
						ACT_LOOKUP: begin
							if (hl) begin
								tgt_q <= pi; st_q <= ST_RPT;
							end else if (last) st_q <= ST_OUT;
						end
						ACT_NEXT: begin
							if (req_q.command == '0 || !idx_ok) st_q <= ST_OUT;
							else if (hn) begin
								tgt_q <= pi; st_q <= ST_RPT;
							end else if (last) st_q <= ST_OUT;
						end
						ACT_ALLOC: begin
							if (req_q.command == '0) st_q <= ST_OUT;
							else if (hf) begin
								tgt_q <= pi; st_q <= ST_FILL;
							end else if (last) begin
								tgt_q <= after(latest_q); st_q <= ST_FILL;
							end
						end
						ACT_MARK: st_q <= idx_ok ? ST_FILL : ST_OUT;
						ACT_FREE_ENTRY, ACT_UPDATE: begin
							st_q <= idx_ok ? ST_RPT : ST_OUT;
							if (idx_ok) have_q <= 1'b1;
						end
						ACT_AGE, ACT_FREE_ROLE, ACT_FREE_ALL:
							if (last) st_q <= ST_OUT;
						default: st_q <= ST_OUT;
					endcase
				end
				ST_FILL: begin
					// keep tgt_q on the original slot until the swap is done
					dst_q <= after(latest_q);
					if (tgt_q == latest_q) st_q <= ST_RPT;
					else begin
						latest_q <= after(latest_q);
						if (after(latest_q) == tgt_q) begin
							st_q <= ST_RPT;
						end else begin
							tmp_q <= (req_q.action == ACT_ALLOC) ? wd
								: (vld_q[tgt_q] ? mem[tgt_q] : '0);
							st_q <= ST_SWAPA;
						end
					end
				end
				ST_SWAPA: begin
					// tmp now gets old dst, swap back into original slot
					tmp_q <= rd_e; st_q <= ST_SWAPB;
				end
				ST_SWAPB: begin
					tgt_q <= dst_q; st_q <= ST_RPT;
				end
				ST_RPT: begin
					have_q <= 1'b0;
					rsp_q.found <= 1'b1;
					rsp_q.result_index <= tgt_q;
					rsp_q.result_size <= wd.size;
					rsp_q.result_time <= wd.time_v;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ovld_q) ovld_q <= 1'b1;
					else if (out.ready) begin
						ovld_q <= 1'b0; st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> st_q == ST_OUT) else $error("result outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !out.valid) else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SWAPB |-> $past(st_q) == ST_SWAPA) else $error("bad swap order");
endmodule
`default_nettype wire

// File: dv/register_query_cache_table_test.sv
// Self-checking testbench for the register query cache table.
// Depends on rqct_pkg, rqct_if and register_query_cache_table.
`default_nettype none
module register_query_cache_table_test;
	import rqct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NE = NUM_ENTRIES;
	localparam int NUM_RANDOM = 1500;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	rqct_if #(.T(req_t)) req_ch (.clk(clk));
	rqct_if #(.T(rsp_t)) rsp_ch (.clk(clk));

	register_query_cache_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(req_ch.sink),
		.out(rsp_ch.source)
	);

	// Shadow copy of the table, kept in step with every word sent
	entry_t      shadow [NE];
	logic [3:0]  shadow_latest;

	req_t pending_words [$];
	rsp_t expected_rsp [$];
	int   errors;
	int   cycles;
	bit   stim_done;
	bit   hold_off;

	// Wrap round the table
	function automatic logic [3:0] slot_after(logic [3:0] i);
		return (i == NE - 1) ? 4'd0 : i + 4'd1;
	endfunction

	// Swap entry i into the slot after latest and advance latest there, unless i is latest
	function automatic logic [3:0] promote(logic [3:0] i);
		logic [3:0] dst;
		entry_t tmp;
		if (i == shadow_latest)
			return i;
		dst = slot_after(shadow_latest);
		if (dst != i) begin
			tmp = shadow[i];
			shadow[i] = shadow[dst];
			shadow[dst] = tmp;
		end
		shadow_latest = dst;
		return dst;
	endfunction

	function automatic void release_slot(int i);
		shadow[i].command = '0;
		shadow[i].size = '0;
	endfunction

	// Apply one word to the shadow table and return the reply it should give
	function automatic rsp_t apply_query(req_t q);
		rsp_t r;
		bit hit;
		logic [3:0] pos;
		int victim;
		bit idx_ok;
		hit = 0;
		pos = '0;
		victim = -1;
		idx_ok = q.entry_index < NE;
		case (q.action)
			ACT_LOOKUP: begin
				for (int i = 0; i < NE; i++)
					if (!hit && shadow[i].role == q.role && shadow[i].command == q.command
							&& shadow[i].argument == q.arg_value) begin
						hit = 1;
						pos = 4'(i);
					end
			end
			ACT_ALLOC: begin
				if (q.command != 0) begin
					for (int i = 0; i < NE; i++)
						if (victim < 0 && shadow[i].command == 0)
							victim = i;
					// Table full: evict the slot after latest
					if (victim < 0) begin
						victim = slot_after(shadow_latest);
						release_slot(victim);
					end
					shadow[victim].role = q.role;
					shadow[victim].command = q.command;
					shadow[victim].argument = '0;
					shadow[victim].size = q.response_size;
					pos = promote(victim[3:0]);
					hit = 1;
				end
			end
			ACT_MARK: begin
				if (idx_ok) begin
					pos = promote(q.entry_index[3:0]);
					hit = 1;
				end
			end
			ACT_AGE: begin
				for (int i = 0; i < NE; i++)
					if (shadow[i].role == q.role && shadow[i].time_v > q.time_value)
						shadow[i].time_v = q.time_value;
			end
			ACT_FREE_ROLE: begin
				for (int i = 0; i < NE; i++)
					if (shadow[i].role == q.role)
						release_slot(i);
			end
			ACT_NEXT: begin
				if (q.command != 0)
					for (int i = 0; i < NE; i++)
						if (!hit && i >= q.entry_index && shadow[i].command == q.command
								&& shadow[i].role == q.role) begin
							hit = 1;
							pos = 4'(i);
						end
			end
			ACT_FREE_ALL: begin
				for (int i = 0; i < NE; i++)
					release_slot(i);
			end
			ACT_FREE_ENTRY: begin
				if (idx_ok) begin
					release_slot(q.entry_index);
					hit = 1;
					pos = q.entry_index[3:0];
				end
			end
			ACT_UPDATE: begin
				if (idx_ok) begin
					shadow[q.entry_index].argument = q.arg_value;
					shadow[q.entry_index].time_v = q.time_value;
					hit = 1;
					pos = q.entry_index[3:0];
				end
			end
			default: ;
		endcase
		r = '0;
		if (hit) begin
			r.found = 1'b1;
			r.result_index = pos;
			r.result_size = shadow[pos].size;
			r.result_time = shadow[pos].time_v;
		end
		return r;
	endfunction

	// Small pools keep roles, commands and arguments colliding often
	function automatic req_t random_query();
		req_t q;
		int pick;
		q.role = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		q.command = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
		q.arg_value = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
		q.response_size = 8'($urandom);
		q.time_value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
		q.entry_index = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 20)      q.action = ACT_LOOKUP;
		else if (pick < 42) q.action = ACT_ALLOC;
		else if (pick < 52) q.action = ACT_MARK;
		else if (pick < 59) q.action = ACT_AGE;
		else if (pick < 63) q.action = ACT_FREE_ROLE;
		else if (pick < 73) q.action = ACT_NEXT;
		else if (pick < 74) q.action = ACT_FREE_ALL;
		else if (pick < 81) q.action = ACT_FREE_ENTRY;
		else if (pick < 97) q.action = ACT_UPDATE;
		else                q.action = 4'($urandom_range(9, 15));
		return q;
	endfunction

	function automatic req_t make_query(logic [3:0] act, logic [7:0] role, logic [31:0] cmd,
			logic [31:0] arg, logic [7:0] sz, logic [31:0] tv, logic [4:0] idx);
		req_t q;
		q.action = act;
		q.role = role;
		q.command = cmd;
		q.arg_value = arg;
		q.response_size = sz;
		q.time_value = tv;
		q.entry_index = idx;
		return q;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Directed words first, then the random stream
	initial begin
		stim_done = 0;
		// lookup on a cleared table matches a free entry
		pending_words.push_back(make_query(ACT_LOOKUP, 0, 0, 0, 0, 0, 0));
		// alloc with command zero is refused
		pending_words.push_back(make_query(ACT_ALLOC, 8'hff, 0, 0, 8'hff, 0, 0));
		pending_words.push_back(make_query(ACT_ALLOC, 8'hff, 32'hffff_ffff, 0, 8'hff, 0, 0));
		pending_words.push_back(make_query(ACT_UPDATE, 0, 0, 32'hffff_ffff, 0,
			32'hffff_ffff, 0));
		pending_words.push_back(make_query(ACT_UPDATE, 0, 0, 32'h1234, 0, 32'hffff_ffff, 15));
		pending_words.push_back(make_query(ACT_LOOKUP, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
			0, 0, 0));
		pending_words.push_back(make_query(ACT_NEXT, 8'hff, 32'hffff_ffff, 0, 0, 0, 0));
		pending_words.push_back(make_query(ACT_NEXT, 8'hff, 0, 0, 0, 0, 0));
		pending_words.push_back(make_query(ACT_NEXT, 8'hff, 32'hffff_ffff, 0, 0, 0, 16));
		pending_words.push_back(make_query(ACT_AGE, 8'hff, 0, 0, 0, 32'h10, 0));
		pending_words.push_back(make_query(ACT_MARK, 0, 0, 0, 0, 0, 15));
		pending_words.push_back(make_query(ACT_MARK, 0, 0, 0, 0, 0, 31));
		pending_words.push_back(make_query(ACT_FREE_ENTRY, 0, 0, 0, 0, 0, 16));
		pending_words.push_back(make_query(ACT_UPDATE, 0, 0, 1, 0, 1, 20));
		// fill past capacity so eviction happens
		for (int i = 0; i < 18; i++)
			pending_words.push_back(make_query(ACT_ALLOC, 1, 32'(i + 1), 0, 8'(i), 0, 0));
		pending_words.push_back(make_query(ACT_FREE_ROLE, 1, 0, 0, 0, 0, 0));
		pending_words.push_back(make_query(ACT_FREE_ENTRY, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_query(ACT_FREE_ALL, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_query(4'hf, 0, 0, 0, 0, 0, 0));
		for (int n = 0; n < NUM_RANDOM; n++) begin
			pending_words.push_back(random_query());
			if (n == NUM_RANDOM / 2)
				pending_words.push_back(make_query(4'hc, 0, 0, 0, 0, 0, 0));
		end
		stim_done = 1;
	end

	// Driver: hold each word until accepted, then draw a fresh gap
	int   send_gap;
	int   sent;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_gap <= 0;
			sent <= 0;
			hold_off <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.push_back(apply_query(req_ch.data));
				sent <= sent + 1;
				// pause once mid-run until every reply is back
				if (sent == 700)
					hold_off <= 1;
			end
			if (hold_off && expected_rsp.size() == 0 && !(req_ch.valid && req_ch.ready))
				hold_off <= 0;
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0 || hold_off || (req_ch.valid && req_ch.ready && sent == 700)
						|| pending_words.size() == 0) begin
					req_ch.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_words.pop_front();
					send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				end
			end
		end
	end

	// Monitor: compare every reply with the oldest expectation
	int   stall;
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected reply %p", $realtime, rsp_ch.data);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_ch.data !== want) begin
						$display("%0t: mismatch expected %p actual %p", $realtime, want,
							rsp_ch.data);
						errors++;
					end
				end
				stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		// the table comes out of reset all zero
		foreach (shadow[i])
			shadow[i] = '0;
		shadow_latest = '0;
		arst_n = 0;
		req_ch.valid = 0;
		req_ch.data = '0;
		rsp_ch.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		fork
			forever begin
				@(posedge clk);
				cycles++;
				if (cycles > CYCLE_LIMIT) begin
					$display("register_query_cache_table_test: errors");
					$finish;
				end
			end
		join_none
		wait (stim_done);
		while (pending_words.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
			@(posedge clk);
		// let any late stray reply surface
		repeat (2 * NE + 20) @(posedge clk);
		if (errors == 0)
			$display("register_query_cache_table_test: clean");
		else
			$display("register_query_cache_table_test: errors");
		$finish;
	end
endmodule
`default_nettype wire
